[rtl/b64_pkg.sv]
// Shared types, codes and alphabet functions for the Base64 stream codec.
package b64_pkg;

    // Mode register codes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // ASCII anchors of the alphabet ranges
    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHR_PLUS    = 8'h2B;
    localparam logic [7:0] CHR_SLASH   = 8'h2F;

    // Sextet range bounds
    localparam logic [5:0] SXT_LOWER = 6'd26;
    localparam logic [5:0] SXT_DIGIT = 6'd52;
    localparam logic [5:0] SXT_PLUS  = 6'd62;

    // Number of result slots in the output buffer
    localparam int unsigned RES_SLOTS = 2;

    // One result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       message_end;
    } t_res;

    // Decoded character
    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } t_sextet;

    // Map a 6-bit value to its alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < SXT_LOWER) begin
            return 8'(CHR_UPPER_A + w);
        end else if (v < SXT_DIGIT) begin
            return 8'(CHR_LOWER_A + w - 8'(SXT_LOWER));
        end else if (v < SXT_PLUS) begin
            return 8'(CHR_DIGIT_0 + w - 8'(SXT_DIGIT));
        end else if (v == SXT_PLUS) begin
            return CHR_PLUS;
        end else begin
            return CHR_SLASH;
        end
    endfunction

    // Map a character to its 6-bit value; flag characters outside the alphabet
    function automatic t_sextet dec_char(input logic [7:0] c);
        t_sextet s;
        s.valid = 1'b1;
        if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) begin
            s.value = 6'(c - CHR_UPPER_A);
        end else if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) begin
            s.value = 6'(c - CHR_LOWER_A + 8'(SXT_LOWER));
        end else if (c >= CHR_DIGIT_0 && c <= CHR_DIGIT_9) begin
            s.value = 6'(c - CHR_DIGIT_0 + 8'(SXT_DIGIT));
        end else if (c == CHR_PLUS) begin
            s.value = SXT_PLUS;
        end else if (c == CHR_SLASH) begin
            s.value = 6'd63;
        end else begin
            s.valid = 1'b0;
            s.value = 6'd0;
        end
        return s;
    endfunction

endpackage

[rtl/b64_if.sv]
// Valid/ready channel interfaces for input words, result words and the mode write.
interface b64_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;
    modport source (output valid, in_byte, in_last, input ready);
    modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface b64_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_end;
    modport source (output valid, out_byte, run_last, message_end, input ready);
    modport sink   (input valid, out_byte, run_last, message_end, output ready);
endinterface

interface b64_cfg_if;
    logic valid;
    logic ready;
    logic mode;
    modport source (output valid, mode, input ready);
    modport sink   (input valid, mode, output ready);
endinterface

[rtl/base64_stream_codec.sv]
// Streaming Base64 encoder/decoder, unpadded, standard alphabet, with a mode register.
// Path: an accepted input word passes the input register, then the result buffer, to the output.
// Throughput: one input word per cycle while each word yields at most one result and the
//   output is not stalled; an encode word that yields two results can hold the input while
//   the single-word output port drains the two-slot result buffer.
// Reset (synchronous, active low): mode encode, group state cleared, buffers empty.
module base64_stream_codec
    import b64_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    b64_in_if.sink       i_in,
    b64_out_if.source    o_out,
    b64_cfg_if.sink      i_cfg
);

    // Configuration and group state
    logic       r_mode;
    logic [1:0] r_phase, n_phase;
    logic [5:0] r_res, n_res;

    // Input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Result buffer
    t_res       r_q [RES_SLOTS];
    t_res       n_q [RES_SLOTS];
    logic [1:0] r_cnt, n_cnt;

    // Results of the word in the input register
    t_res       w_r0, w_r1;
    logic [1:0] w_nres;
    logic [1:0] w_ph;
    t_sextet    w_sx;
    logic [5:0] w_c0, w_c1;
    logic [1:0] w_cnt_pop;
    logic       w_pop, w_adv, w_in_acc;

    assign i_cfg.ready = 1'b1;
    assign o_out.valid       = (r_cnt != 2'd0);
    assign o_out.out_byte    = r_q[0].out_byte;
    assign o_out.run_last    = r_q[0].run_last;
    assign o_out.message_end = r_q[0].message_end;

    assign w_pop     = o_out.valid && o_out.ready;
    assign w_cnt_pop = r_cnt - {1'b0, w_pop};
    assign w_adv     = r_in_vld && (({1'b0, w_cnt_pop} + {1'b0, w_nres}) <= 3'(RES_SLOTS));
    assign i_in.ready = !r_in_vld || w_adv;
    assign w_in_acc  = i_in.valid && i_in.ready;

    // Compute the results and next group state for the held word
    always_comb begin
        w_r0    = '0;
        w_r1    = '0;
        w_nres  = 2'd0;
        n_phase = r_phase;
        n_res   = r_res;
        w_c0    = 6'd0;
        w_c1    = 6'd0;
        w_ph    = (r_phase == 2'd3) ? 2'd0 : r_phase;
        w_sx    = dec_char(r_in_byte);
        if (r_mode == MODE_ENCODE) begin
            case (w_ph)
                2'd0: begin
                    w_c0    = r_in_byte[7:2];
                    n_res   = {r_in_byte[1:0], 4'b0000};
                    n_phase = 2'd1;
                end
                2'd1: begin
                    w_c0    = r_res | {2'b00, r_in_byte[7:4]};
                    n_res   = {r_in_byte[3:0], 2'b00};
                    n_phase = 2'd2;
                end
                default: begin
                    w_c0    = r_res | {4'b0000, r_in_byte[7:6]};
                    n_res   = 6'd0;
                    n_phase = 2'd0;
                end
            endcase
            w_r0.out_byte = enc_char(w_c0);
            w_nres = 2'd1;
            // Second character: end of group, or flush of a pending partial character
            if (w_ph == 2'd2) begin
                w_c1 = r_in_byte[5:0];
                w_nres = 2'd2;
            end else if (r_in_last) begin
                w_c1 = n_res;
                w_nres = 2'd2;
            end
            w_r1.out_byte = enc_char(w_c1);
        end else if (w_sx.valid) begin
            case (r_phase)
                2'd0: begin
                    n_res   = w_sx.value;
                    n_phase = 2'd1;
                end
                2'd1: begin
                    w_r0.out_byte = {r_res, w_sx.value[5:4]};
                    n_res   = {2'b00, w_sx.value[3:0]};
                    n_phase = 2'd2;
                    w_nres  = 2'd1;
                end
                2'd2: begin
                    w_r0.out_byte = {r_res[3:0], w_sx.value[5:2]};
                    n_res   = {4'b0000, w_sx.value[1:0]};
                    n_phase = 2'd3;
                    w_nres  = 2'd1;
                end
                default: begin
                    w_r0.out_byte = {r_res[1:0], w_sx.value};
                    n_res   = 6'd0;
                    n_phase = 2'd0;
                    w_nres  = 2'd1;
                end
            endcase
        end
        // Flag the final result of this word
        w_r0.run_last    = (w_nres == 2'd1);
        w_r0.message_end = (w_nres == 2'd1) && r_in_last;
        w_r1.run_last    = 1'b1;
        w_r1.message_end = r_in_last;
        // Last word returns the group to its start
        if (r_in_last) begin
            n_phase = 2'd0;
            n_res   = 6'd0;
        end
    end

    // Shift out the popped word and append the new results
    always_comb begin
        n_q = r_q;
        if (w_pop) begin
            n_q[0] = r_q[1];
        end
        if (w_adv) begin
            case (w_cnt_pop)
                2'd0: begin
                    n_q[0] = w_r0;
                    n_q[1] = w_r1;
                end
                2'd1: begin
                    n_q[1] = w_r0;
                end
                default: begin
                end
            endcase
        end
        n_cnt = w_cnt_pop + (w_adv ? w_nres : 2'd0);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ENCODE;
            r_phase  <= 2'd0;
            r_res    <= 6'd0;
            r_in_vld <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_in_acc) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_mode  <= i_cfg.mode;
                r_phase <= 2'd0;
                r_res   <= 6'd0;
            end else if (w_adv) begin
                r_phase <= n_phase;
                r_res   <= n_res;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.in_last;
        end
        r_q <= n_q;
    end

endmodule

[rtl/b64_chk.sv]
// Port-level assertions for the Base64 stream codec, bound to its top level.
module b64_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_run_last,
    input logic       i_out_message_end
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte) && $stable(i_out_run_last)
            && $stable(i_out_message_end))
        else $error("stalled result word changed");

    // Message end only on the final result of a word
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_message_end |-> i_out_run_last)
        else $error("message end without run last");

    // Second result of a word is already buffered behind the first
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_run_last |=> i_out_valid)
        else $error("second result of a word missing");

    // Reset empties the result buffer
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind base64_stream_codec b64_chk u_b64_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_byte        (o_out.out_byte),
    .i_out_run_last    (o_out.run_last),
    .i_out_message_end (o_out.message_end)
);
